@@ hdl/huffman_tree_builder_core_assert.svh @@
// Assertion macros shared by the tree builder RTL
`ifndef HUFFMAN_TREE_BUILDER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_BUILDER_CORE_ASSERT_SVH

// Check an expression at every rising clock edge outside reset
`define HTB_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define HTB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define HTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/htb_pkg.sv @@
// Types and constants of the Huffman tree builder
package htb_pkg;

	localparam int ID_W = 10;
	localparam int WEIGHT_W = 33;
	localparam int FREQ_W = 24;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_MERGE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_MERGED = 2'd0;
	localparam logic [1:0] ST_ROOT = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] symbol;
		logic is_eof;
		logic [FREQ_W-1:0] frequency;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ID_W-1:0] node_id;
		logic [ID_W-1:0] left_id;
		logic [ID_W-1:0] right_id;
		logic [WEIGHT_W-1:0] weight;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

endpackage

@@ hdl/htb_ram.sv @@
// Generic simple dual-port RAM with registered read
module htb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/huffman_tree_builder_core.sv @@
// Huffman tree builder: weight-ordered node list kept in a circular RAM.
// Insert walks the list down from the tail, moving up each stored entry whose
// weight is at or above the new leaf, then writes the leaf in the gap; insert into
// an empty list writes the leaf at once and full-list overflow only emits a status.
// Merge reads the two smallest entries, places the new node the same way as insert,
// then emits; when only two entries are stored the new node is written at once.
// Merge of an empty list emits a status and merge of a single root emits the root.
// Clear and unused commands do not leave idle. The walk moves one entry per cycle
// through the RAM's single read and single write port. A result waits in an output
// register and does not block the next transaction unless a further result is
// ready before it is taken. No clearing pass is needed after reset.
`include "huffman_tree_builder_core_assert.svh"

module huffman_tree_builder_core #(
	parameter int SYMBOLS = 256,
	parameter int FREQ_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input htb_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output htb_pkg::result_t result
);

	localparam int CAP = SYMBOLS + 1;
	localparam int AW = $clog2(CAP);
	localparam int CW = $clog2(CAP + 1);
	localparam logic [AW-1:0] LAST = AW'(CAP - 1);
	localparam logic [AW:0] CAP_W = (AW+1)'(CAP);
	localparam logic [CW-1:0] CAP_C = CW'(CAP);
	localparam logic [CW-1:0] ONE_C = CW'(1);
	localparam logic [CW-1:0] TWO_C = CW'(2);
	localparam logic [63:0] FMASK64 = (64'd1 << FREQ_BITS) - 64'd1;
	localparam logic [htb_pkg::FREQ_W-1:0] FMASK = FMASK64[htb_pkg::FREQ_W-1:0];
	localparam logic [htb_pkg::ID_W-1:0] EOF_ID = htb_pkg::ID_W'(SYMBOLS % 1024);
	localparam logic [htb_pkg::ID_W-1:0] ID_FIRST = htb_pkg::ID_W'((SYMBOLS + 1) % 1024);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_M0 = 6'b000010,
		S_M1 = 6'b000100,
		S_SCAN = 6'b001000,
		S_PUT = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d, p_q, p_d;
	logic [CW-1:0] count_q, count_d, k_q, k_d;
	logic [htb_pkg::ID_W-1:0] next_id_q, next_id_d;
	htb_pkg::entry_t new_q, new_d, left_q, left_d;
	logic pend_q, pend_d;
	htb_pkg::result_t pend_res_q, pend_res_d, result_q, result_d;
	logic result_valid_q, result_valid_d;

	logic we;
	logic [AW-1:0] waddr, raddr;
	htb_pkg::entry_t wdata, rdata, ins_entry, merged;

	logic [AW:0] tail_sum, head1_sum, head2_sum;
	logic [AW-1:0] tail, head1, head2, p_inc, p_dec;
	logic [htb_pkg::WEIGHT_W:0] sum_full;
	logic [htb_pkg::WEIGHT_W-1:0] sum_sat;
	logic accept, out_free;

	htb_ram #(
		.WIDTH($bits(htb_pkg::entry_t)),
		.DEPTH(CAP)
	) u_list (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free = !result_valid_q || !result_stall;

	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q) - (AW+1)'(1);
	assign tail = (tail_sum >= CAP_W) ? AW'(tail_sum - CAP_W) : tail_sum[AW-1:0];
	assign head1_sum = (AW+1)'(head_q) + (AW+1)'(1);
	assign head1 = (head1_sum >= CAP_W) ? AW'(head1_sum - CAP_W) : head1_sum[AW-1:0];
	assign head2_sum = (AW+1)'(head_q) + (AW+1)'(2);
	assign head2 = (head2_sum >= CAP_W) ? AW'(head2_sum - CAP_W) : head2_sum[AW-1:0];
	assign p_inc = (p_q == LAST) ? '0 : p_q + AW'(1);
	assign p_dec = (p_q == '0) ? LAST : p_q - AW'(1);

	assign sum_full = {1'b0, left_q.weight} + {1'b0, rdata.weight};
	assign sum_sat = sum_full[htb_pkg::WEIGHT_W] ? '1 : sum_full[htb_pkg::WEIGHT_W-1:0];
	assign merged = '{id: next_id_q, weight: sum_sat};

	assign ins_entry.id = item.is_eof ? EOF_ID : {2'b00, item.symbol};
	assign ins_entry.weight = item.is_eof ? htb_pkg::WEIGHT_W'(1)
		: htb_pkg::WEIGHT_W'(item.frequency & FMASK);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		next_id_d = next_id_q;
		p_d = p_q;
		k_d = k_q;
		new_d = new_q;
		left_d = left_q;
		pend_d = pend_q;
		pend_res_d = pend_res_q;
		result_d = result_q;
		result_valid_d = result_valid_q && result_stall;
		we = 1'b0;
		waddr = head_q;
		wdata = new_q;
		raddr = tail;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (item.cmd)
						htb_pkg::CMD_INSERT: begin
							if (count_q == CAP_C) begin
								pend_res_d = '{status: htb_pkg::ST_OVERFLOW, default: '0};
								state_d = S_EMIT;
							end else begin
								new_d = ins_entry;
								pend_d = 1'b0;
								if (count_q == '0) begin
									we = 1'b1;
									wdata = ins_entry;
									count_d = ONE_C;
								end else begin
									p_d = tail;
									k_d = count_q;
									state_d = S_SCAN;
								end
							end
						end
						htb_pkg::CMD_MERGE: begin
							if (count_q == '0) begin
								pend_res_d = '{status: htb_pkg::ST_EMPTY, default: '0};
								state_d = S_EMIT;
							end else begin
								raddr = head_q;
								state_d = S_M0;
							end
						end
						htb_pkg::CMD_CLEAR: begin
							count_d = '0;
							next_id_d = ID_FIRST;
						end
						default: begin
						end
					endcase
				end
			end
			S_M0: begin
				if (count_q == ONE_C) begin
					pend_res_d = '{status: htb_pkg::ST_ROOT, node_id: rdata.id,
						weight: rdata.weight, default: '0};
					state_d = S_EMIT;
				end else begin
					left_d = rdata;
					raddr = head1;
					state_d = S_M1;
				end
			end
			S_M1: begin
				new_d = merged;
				next_id_d = next_id_q + htb_pkg::ID_W'(1);
				pend_res_d = '{status: htb_pkg::ST_MERGED, node_id: next_id_q,
					left_id: left_q.id, right_id: rdata.id, weight: sum_sat};
				pend_d = 1'b1;
				head_d = head2;
				if (count_q == TWO_C) begin
					we = 1'b1;
					waddr = head2;
					wdata = merged;
					count_d = ONE_C;
					state_d = S_EMIT;
				end else begin
					count_d = count_q - TWO_C;
					p_d = tail;
					k_d = count_q - TWO_C;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				raddr = p_dec;
				we = 1'b1;
				waddr = p_inc;
				if (rdata.weight >= new_q.weight) begin
					wdata = rdata;
					if (k_q > ONE_C) begin
						p_d = p_dec;
						k_d = k_q - ONE_C;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					wdata = new_q;
					count_d = count_q + ONE_C;
					state_d = pend_q ? S_EMIT : S_IDLE;
				end
			end
			S_PUT: begin
				we = 1'b1;
				waddr = p_q;
				wdata = new_q;
				count_d = count_q + ONE_C;
				state_d = pend_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (out_free) begin
					result_d = pend_res_q;
					result_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			next_id_q <= ID_FIRST;
			pend_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			next_id_q <= next_id_d;
			pend_q <= pend_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= p_d;
		k_q <= k_d;
		new_q <= new_d;
		left_q <= left_d;
		pend_res_q <= pend_res_d;
		result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	`HTB_ASSERT_ALWAYS(a_count_cap, count_q <= CAP_C, "entry count beyond capacity")
	`HTB_ASSERT_ALWAYS(a_head_range, head_q <= LAST, "head pointer out of range")
	`HTB_ASSERT_SAME(a_scan_ports, (state_q == S_SCAN) && we, waddr != raddr, "scan port clash")
	`HTB_ASSERT_NEXT(a_clear, accept && (item.cmd == htb_pkg::CMD_CLEAR), count_q == '0, "clear failed")

endmodule

@@ verif/huffman_tree_builder_core_tb.sv @@
// Testbench for the Huffman tree builder core: random and directed items checked against a node-list predictor
module huffman_tree_builder_core_tb;

	localparam int SYMBOLS = 256;
	localparam int CAPACITY = SYMBOLS + 1;
	localparam int HOLD_LEN = 3000;
	localparam logic [htb_pkg::WEIGHT_W-1:0] WEIGHT_SAT = '1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	htb_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	htb_pkg::result_t result;

	huffman_tree_builder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	logic [htb_pkg::ID_W-1:0] list_ids[CAPACITY];
	logic [htb_pkg::WEIGHT_W-1:0] list_weights[CAPACITY];
	int list_count;
	logic [htb_pkg::ID_W-1:0] next_node_id;

	htb_pkg::item_t pending_items[$];
	htb_pkg::result_t expected_results[$];
	int error_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_req;
	int hold_ack;
	int hold_cnt;
	logic item_busy;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic void place_entry(input logic [htb_pkg::ID_W-1:0] id,
			input logic [htb_pkg::WEIGHT_W-1:0] w);
		int pos;
		pos = 0;
		while (pos < list_count && list_weights[pos] < w)
			pos++;
		for (int i = list_count; i > pos; i--) begin
			list_ids[i] = list_ids[i-1];
			list_weights[i] = list_weights[i-1];
		end
		list_ids[pos] = id;
		list_weights[pos] = w;
		list_count++;
	endfunction

	function automatic void predict_tree_step(input htb_pkg::item_t it);
		htb_pkg::result_t r;
		logic [htb_pkg::WEIGHT_W:0] sum;
		r = '0;
		unique case (it.cmd)
			htb_pkg::CMD_INSERT: begin
				if (list_count >= CAPACITY) begin
					r.status = htb_pkg::ST_OVERFLOW;
					expected_results.push_back(r);
				end else if (it.is_eof)
					place_entry(htb_pkg::ID_W'(SYMBOLS), htb_pkg::WEIGHT_W'(1));
				else
					place_entry(htb_pkg::ID_W'(it.symbol), htb_pkg::WEIGHT_W'(it.frequency));
			end
			htb_pkg::CMD_MERGE: begin
				if (list_count == 0) begin
					r.status = htb_pkg::ST_EMPTY;
				end else if (list_count == 1) begin
					r.status = htb_pkg::ST_ROOT;
					r.node_id = list_ids[0];
					r.weight = list_weights[0];
				end else begin
					sum = {1'b0, list_weights[0]} + {1'b0, list_weights[1]};
					r.status = htb_pkg::ST_MERGED;
					r.left_id = list_ids[0];
					r.right_id = list_ids[1];
					r.node_id = next_node_id;
					r.weight = sum[htb_pkg::WEIGHT_W] ? WEIGHT_SAT : sum[htb_pkg::WEIGHT_W-1:0];
					for (int i = 0; i < list_count - 2; i++) begin
						list_ids[i] = list_ids[i+2];
						list_weights[i] = list_weights[i+2];
					end
					list_count -= 2;
					next_node_id = next_node_id + htb_pkg::ID_W'(1);
					place_entry(r.node_id, r.weight);
				end
				expected_results.push_back(r);
			end
			htb_pkg::CMD_CLEAR: begin
				list_count = 0;
				next_node_id = htb_pkg::ID_W'(SYMBOLS + 1);
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_busy <= 1'b0;
		else
			item_busy <= item_valid && item_stall;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else if (!item_busy) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				item <= pending_items.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ack <= 0;
			hold_cnt <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_cnt <= HOLD_LEN;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_cnt > 0) begin
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			predict_tree_step(item);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result status", 64'(result.status), 64'd0);
			end else begin
				htb_pkg::result_t want;
				want = expected_results.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.node_id !== want.node_id)
					report_mismatch("node_id", 64'(result.node_id), 64'(want.node_id));
				if (result.left_id !== want.left_id)
					report_mismatch("left_id", 64'(result.left_id), 64'(want.left_id));
				if (result.right_id !== want.right_id)
					report_mismatch("right_id", 64'(result.right_id), 64'(want.right_id));
				if (result.weight !== want.weight)
					report_mismatch("weight", 64'(result.weight), 64'(want.weight));
			end
		end
	end

	function automatic htb_pkg::item_t make_item(input logic [1:0] cmd, input logic [7:0] sym,
			input logic eof, input logic [htb_pkg::FREQ_W-1:0] freq);
		htb_pkg::item_t it;
		it.cmd = cmd;
		it.symbol = sym;
		it.is_eof = eof;
		it.frequency = freq;
		return it;
	endfunction

	function automatic logic [htb_pkg::FREQ_W-1:0] random_frequency();
		unique case ($urandom_range(3))
			0: return htb_pkg::FREQ_W'($urandom_range(8));
			1: return htb_pkg::FREQ_W'($urandom_range(1000));
			2: return htb_pkg::FREQ_W'($urandom);
			default: return {htb_pkg::FREQ_W{1'b1}} - htb_pkg::FREQ_W'($urandom_range(3));
		endcase
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic queue_tree(input int leaves, input int merges);
		pending_items.push_back(make_item(htb_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom),
			htb_pkg::FREQ_W'($urandom)));
		for (int i = 0; i < leaves; i++)
			pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'($urandom),
				($urandom_range(15) == 0), random_frequency()));
		for (int i = 0; i < merges; i++)
			pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'($urandom), 1'($urandom),
				htb_pkg::FREQ_W'($urandom)));
	endtask

	task automatic queue_noise(input int count);
		for (int i = 0; i < count; i++)
			pending_items.push_back(make_item(2'($urandom_range(3)), 8'($urandom), 1'($urandom),
				random_frequency()));
	endtask

	initial begin
		int sent;
		int leaves;
		arst_n = 1'b0;
		hold_req = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		list_count = 0;
		next_node_id = htb_pkg::ID_W'(SYMBOLS + 1);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'hFF, 1'b0, '1));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'h55, 1'b1, 24'hAAAAAA));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'hAA, 1'b0, 24'd1));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'h12, 1'b0, '1));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(2'd3, 8'hFF, 1'b1, '1));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		pending_items.push_back(make_item(htb_pkg::CMD_CLEAR, 8'hFF, 1'b1, '1));
		pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		wait_drained();

		// fill the list to capacity with top weights, then overflow it and merge it down to a single root
		pending_items.push_back(make_item(htb_pkg::CMD_CLEAR, 8'h00, 1'b0, '0));
		for (int i = 0; i < CAPACITY; i++)
			pending_items.push_back(make_item(htb_pkg::CMD_INSERT, i[7:0], 1'b0, '1));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'h01, 1'b0, 24'd5));
		pending_items.push_back(make_item(htb_pkg::CMD_INSERT, 8'h02, 1'b1, 24'd5));
		for (int i = 0; i < 260; i++)
			pending_items.push_back(make_item(htb_pkg::CMD_MERGE, 8'h00, 1'b0, '0));
		wait_drained();

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			if (phase == 2) begin
				hold_req = hold_req + 1;
				queue_tree(12, 14);
				queue_tree(8, 10);
				do
					@(posedge clk);
				while (hold_ack != hold_req || hold_cnt > 0);
				wait_drained();
			end
			for (int s = 0; s < 330; s += 0) begin
				if ($urandom_range(9) < 8) begin
					leaves = ($urandom_range(19) == 0) ? int'($urandom_range(40, 80))
						: int'($urandom_range(1, 12));
					queue_tree(leaves, leaves + int'($urandom_range(2)));
					s += 2 * leaves + 3;
				end else begin
					queue_noise(8);
					s += 8;
				end
				if ($urandom_range(9) == 0)
					wait_drained();
			end
			wait_drained();
		end
		if (error_count == 0)
			$display("PASS huffman_tree_builder_core");
		else
			$display("FAIL huffman_tree_builder_core");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAIL huffman_tree_builder_core");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/htb_pkg.sv
hdl/htb_ram.sv
hdl/huffman_tree_builder_core.sv
verif/huffman_tree_builder_core_tb.sv
